// ===== sv/blc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types, constants and helpers of the backlight supply and level
// controller.
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_STEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEBUG_HOLD  = 3'd7;

  localparam logic [2:0] MODE_PRESET = 3'd0;
  localparam logic [2:0] MODE_STEP   = 3'd1;
  localparam logic [2:0] MODE_POT22  = 3'd2;
  localparam logic [2:0] MODE_POT47  = 3'd3;

  localparam logic [9:0] PRESET_HIGH  = 10'd716;
  localparam logic [9:0] PRESET_MID   = 10'd409;
  localparam logic [9:0] POT22_OFFSET = 10'd0;
  localparam logic [4:0] POT22_SLOPE  = 5'd1;
  localparam logic [9:0] POT47_OFFSET = 10'd0;
  localparam logic [4:0] POT47_SLOPE  = 5'd1;

  localparam logic [8:0]  RESTART_LIMIT = 9'h1F0;
  localparam logic [15:0] HOLD_MAX      = 16'hFFFF;
  localparam logic [9:0]  LEVEL_MAX     = 10'd1023;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  volt_low;
    logic [9:0]  volt_high;
    logic [9:0]  max_current;
    logic [9:0]  coef_min;
    logic [9:0]  coef_max;
    logic [9:0]  coef_step;
    logic [15:0] debug_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [9:0] voltage;
    logic [9:0] current;
    logic [3:0] buttons;
    logic       mem_button;
    logic [9:0] pot_level;
    logic       timer_tick;
  } item_t;

  typedef struct packed {
    logic        power_on;
    logic        mem_switch_on;
    logic [9:0]  pwm_coefficient;
    logic        debug_active;
    logic        mode_error;
  } result_t;

  typedef struct packed {
    logic [3:0]  prev_buttons;
    logic        prev_mem_level;
    logic        switch_closed;
    logic [8:0]  restart_count;
    logic        mem_switch;
    logic        in_debug;
    logic        timer_running;
    logic [15:0] hold_count;
    logic [9:0]  level;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    mode: 3'd0, volt_low: 10'd0, volt_high: 10'd1023, max_current: 10'd1023,
    coef_min: 10'd102, coef_max: 10'd1023, coef_step: 10'd32,
    debug_hold_ticks: 16'd100
  };

  localparam state_t STATE_RESET = '{
    prev_buttons: 4'hF, prev_mem_level: 1'b1, switch_closed: 1'b1,
    restart_count: 9'd0, mem_switch: 1'b0, in_debug: 1'b0,
    timer_running: 1'b0, hold_count: 16'd0, level: 10'd102
  };

  // linear pot map, saturated to the level range
  function automatic logic [9:0] pot_map(input logic [9:0] pot, input logic [9:0] base,
                                         input logic [9:0] offset, input logic [4:0] slope);
    logic signed [17:0] diff;
    logic signed [17:0] v;
    diff = $signed({8'd0, pot}) - $signed({8'd0, offset});
    v = $signed({8'd0, base}) + $signed({13'd0, slope}) * diff;
    if (v < 18'sd0) begin
      pot_map = 10'd0;
    end else if (v > $signed({8'd0, LEVEL_MAX})) begin
      pot_map = LEVEL_MAX;
    end else begin
      pot_map = v[9:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/backlight_supply_and_level_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// backlight_supply_and_level_controller
// Supply supervision, power switch restart, memory button handling and
// dimming level control, one control pass per input beat.
// ----------------------------------------------------------------------------
// a beat goes from the input register through the pass into the result register
// throughput: 1 beat per cycle unless out_tready stalls the result register
// a stalled result register holds one beat while one more waits in the input register
// reset: synchronous, active low; clears state, configuration and both pipeline valids
module backlight_supply_and_level_controller (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // voltage[9:0], current[19:10], buttons[23:20], mem_button[24],
  // pot_level[34:25], timer_tick[35], zero[39:36]
  input  wire  [blc_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // power_on[0], mem_switch_on[1], pwm_coefficient[11:2], debug_active[12],
  // mode_error[13], zero[15:14]
  output logic [blc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [blc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [blc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import blc_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  state_t  state_r, state_nxt, pass_state;
  item_t   item_r, item_in;
  result_t out_r, pass_res;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance, fire, in_fire;

  assign item_in.voltage    = in_tdata[9:0];
  assign item_in.current    = in_tdata[19:10];
  assign item_in.buttons    = in_tdata[23:20];
  assign item_in.mem_button = in_tdata[24];
  assign item_in.pot_level  = in_tdata[34:25];
  assign item_in.timer_tick = in_tdata[35];

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign fire      = s1_valid_r && advance;

  blc_pass u_pass (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (pass_state),
    .res       (pass_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:        cfg_nxt.mode = cfg_data[2:0];
        REG_VOLT_LOW:    cfg_nxt.volt_low = cfg_data[9:0];
        REG_VOLT_HIGH:   cfg_nxt.volt_high = cfg_data[9:0];
        REG_MAX_CURRENT: cfg_nxt.max_current = cfg_data[9:0];
        REG_COEF_MIN:    cfg_nxt.coef_min = cfg_data[9:0];
        REG_COEF_MAX:    cfg_nxt.coef_max = cfg_data[9:0];
        REG_COEF_STEP:   cfg_nxt.coef_step = cfg_data[9:0];
        REG_DEBUG_HOLD:  cfg_nxt.debug_hold_ticks = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = fire ? pass_state : state_r;
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      state_r     <= STATE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_in;
    end
    if (fire) begin
      out_r <= pass_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.mode_error, out_r.debug_active, out_r.pwm_coefficient,
                       out_r.mem_switch_on, out_r.power_on};

  a_restart_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.restart_count <= RESTART_LIMIT)
    else $error("restart count past limit");

  a_debug_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_debug |=> state_r.in_debug)
    else $error("debug mode left");

  a_debug_power: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_debug |-> state_r.switch_closed)
    else $error("switch open in debug mode");

  a_mode_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mode_error) |-> (cfg_r.mode > MODE_POT47))
    else $error("mode error with valid mode");

endmodule
`default_nettype wire

// ===== sv/blc_pass.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blc_pass
// One control pass: supply supervision, restart, memory button, debug entry
// and dimming level update, from the current state to the next one.
// ----------------------------------------------------------------------------
module blc_pass (
  input  blc_pkg::cfg_t    cfg,
  input  blc_pkg::state_t  state,
  input  blc_pkg::item_t   item,
  output blc_pkg::state_t  state_nxt,
  output blc_pkg::result_t res
);
  import blc_pkg::*;

  always_comb begin
    state_t      s;
    logic [3:0]  edges;
    logic [10:0] up_sum;
    logic signed [11:0] dn_sum;
    logic        err;
    s = state;
    err = 1'b0;
    up_sum = '0;
    dn_sum = '0;
    edges = '0;

    // hold timer
    if (s.timer_running && item.timer_tick && s.hold_count != HOLD_MAX) begin
      s.hold_count = s.hold_count + 16'd1;
    end

    // supply check
    if (!s.in_debug) begin
      if (item.voltage < cfg.volt_low || item.voltage > cfg.volt_high ||
          item.current > cfg.max_current) begin
        s.switch_closed = 1'b0;
        s.restart_count = '0;
      end
    end

    // restart after a run of good samples
    if (!s.switch_closed) begin
      if (item.voltage > cfg.volt_low && item.voltage < cfg.volt_high) begin
        s.restart_count = s.restart_count + 9'd1;
      end else begin
        s.restart_count = '0;
      end
      if (s.restart_count > RESTART_LIMIT) begin
        s.switch_closed = 1'b1;
        s.restart_count = '0;
      end
    end

    // memory button
    if (item.mem_button != s.prev_mem_level) begin
      if (item.mem_button) begin
        if (!s.in_debug) begin
          s.timer_running = 1'b0;
        end
        s.mem_switch = ~s.mem_switch;
      end else if (!s.in_debug) begin
        s.hold_count = '0;
        s.timer_running = 1'b1;
      end
    end
    s.prev_mem_level = item.mem_button;

    // debug entry
    if (s.hold_count > cfg.debug_hold_ticks) begin
      s.hold_count = '0;
      s.timer_running = 1'b0;
      s.in_debug = 1'b1;
      s.switch_closed = 1'b1;
    end

    // dimming level
    case (cfg.mode)
      MODE_PRESET, MODE_STEP: begin
        edges = ~item.buttons & s.prev_buttons;
        s.prev_buttons = item.buttons;
        if (edges[0]) begin
          s.level = cfg.coef_min;
        end
        if (edges[1]) begin
          s.level = cfg.coef_max;
        end
        if (cfg.mode == MODE_PRESET) begin
          if (edges[2]) begin
            s.level = PRESET_HIGH;
          end
          if (edges[3]) begin
            s.level = PRESET_MID;
          end
        end else begin
          if (edges[2]) begin
            up_sum = {1'b0, s.level} + {1'b0, cfg.coef_step};
            if (up_sum > {1'b0, cfg.coef_max} || up_sum < {1'b0, cfg.coef_min}) begin
              s.level = cfg.coef_max;
            end else begin
              s.level = up_sum[9:0];
            end
          end
          if (edges[3]) begin
            dn_sum = $signed({2'b0, s.level}) - $signed({2'b0, cfg.coef_step});
            if (dn_sum < $signed({2'b0, cfg.coef_min}) ||
                dn_sum > $signed({2'b0, cfg.coef_max})) begin
              s.level = cfg.coef_min;
            end else begin
              s.level = dn_sum[9:0];
            end
          end
        end
      end
      MODE_POT22: begin
        s.level = pot_map(item.pot_level, cfg.coef_min, POT22_OFFSET, POT22_SLOPE);
      end
      MODE_POT47: begin
        s.level = pot_map(item.pot_level, cfg.coef_min, POT47_OFFSET, POT47_SLOPE);
      end
      default: begin
        err = 1'b1;
      end
    endcase

    state_nxt = s;
    res.power_on = s.switch_closed;
    res.mem_switch_on = s.mem_switch;
    res.pwm_coefficient = s.level;
    res.debug_active = s.in_debug;
    res.mode_error = err;
  end

endmodule
`default_nettype wire
